### design/assert_macros.svh
// Assertion macros shared by the pixel unpack design files.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### design/dbpu_pkg.sv
// Shared constants for the bitmap pixel unpack block.
// No dependencies; used by every other design file except assert_macros.svh.
package dbpu_pkg;

  localparam int MAX_CHANNEL_BITS = 8;

  localparam int WORD_W      = 32;
  localparam int CHAN_W      = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_USE_BITFIELDS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH_MODE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RED_MASK      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GREEN_MASK    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLUE_MASK     = 3'd4;

  // Depth codes. The spare code behaves like 24 and 32 bit.
  localparam logic [1:0] DEPTH_16    = 2'd0;
  localparam logic [1:0] DEPTH_24    = 2'd1;
  localparam logic [1:0] DEPTH_32    = 2'd2;
  localparam logic [1:0] DEPTH_SPARE = 2'd3;

  // Masks in effect after reset and in plain 24 and 32 bit mode.
  localparam logic [WORD_W-1:0] MASK_RED_888   = 32'h00FF_0000;
  localparam logic [WORD_W-1:0] MASK_GREEN_888 = 32'h0000_FF00;
  localparam logic [WORD_W-1:0] MASK_BLUE_888  = 32'h0000_00FF;

  // Masks of plain 16 bit mode.
  localparam logic [WORD_W-1:0] MASK_RED_555   = 32'h0000_7C00;
  localparam logic [WORD_W-1:0] MASK_GREEN_555 = 32'h0000_03E0;
  localparam logic [WORD_W-1:0] MASK_BLUE_555  = 32'h0000_001F;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

endpackage

### design/dbpu_if.sv
// Request channel interfaces for pixel words in and RGBA results out.
// Depends on dbpu_pkg for the field widths.
interface dbpu_pixel_in_if;
  logic                            valid;
  logic                            ready;
  logic [dbpu_pkg::WORD_W-1:0]     pixel_word;
  logic                            pixel_present;

  modport source (output valid, output pixel_word, output pixel_present, input ready);
  modport sink   (input valid, input pixel_word, input pixel_present, output ready);
endinterface

interface dbpu_pixel_out_if;
  logic                            valid;
  logic                            ready;
  logic [dbpu_pkg::CHAN_W-1:0]     red;
  logic [dbpu_pkg::CHAN_W-1:0]     green;
  logic [dbpu_pkg::CHAN_W-1:0]     blue;
  logic [dbpu_pkg::CHAN_W-1:0]     alpha;
  logic                            mask_error;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output mask_error, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input mask_error, output ready);
endinterface

### design/dbpu_mask_decode.sv
// Reduces one channel mask to a shift, a field width and a scaling reciprocal.
// Depends on dbpu_pkg and assert_macros.svh; outputs are registered.
`include "assert_macros.svh"

module dbpu_mask_decode #(
  parameter int MaxBits = dbpu_pkg::MAX_CHANNEL_BITS,
  parameter int KW      = $clog2(MaxBits + 1),
  parameter int MW      = MaxBits + 11
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [dbpu_pkg::WORD_W-1:0]     mask,
  output logic [4:0]                      shift,
  output logic [KW-1:0]                   width,
  output logic [MaxBits-1:0]              field_mask,
  output logic [MW-1:0]                   recip,
  output logic                            err
);

  localparam int TabDepth = 2 ** KW;

  logic [MW-1:0]                   recip_tab [TabDepth];
  logic [dbpu_pkg::WORD_W-1:0]     low_bit;
  logic [5:0]                      ones;
  logic [4:0]                      tz;
  logic                            contiguous;
  logic                            bad;
  logic [KW-1:0]                   width_next;
  logic [MaxBits-1:0]              fmask_next;

  // Reciprocal of 2*(2^k-1), scaled by 2^(2k+10), rounded up. That scale keeps
  // the product exact for every field value up to 2^k-1.
  for (genvar g = 0; g < TabDepth; g++) begin : g_recip
    if (g >= 1 && g <= MaxBits) begin : g_used
      localparam longint unsigned Div = 2 * ((64'd1 << g) - 64'd1);
      localparam longint unsigned Val = ((64'd1 << (2 * g + 10)) + Div - 64'd1) / Div;
      assign recip_tab[g] = MW'(Val);
    end else begin : g_unused
      assign recip_tab[g] = '0;
    end
  end

  always_comb begin
    low_bit    = mask & (~mask + 32'd1);
    // Adding the lowest set bit clears a contiguous run entirely.
    contiguous = ((mask + low_bit) & mask) == '0;
    ones = 6'($countones(mask));
    tz   = '0;
    for (int i = 0; i < dbpu_pkg::WORD_W; i++) begin
      if (low_bit[i]) begin
        tz = tz | 5'(i);
      end
    end
    bad        = (mask == '0) || !contiguous || (ones > 6'(MaxBits));
    width_next = bad ? '0 : KW'(ones);
    for (int i = 0; i < MaxBits; i++) begin
      fmask_next[i] = !bad && (i < int'(ones));
    end
  end

  always_ff @(posedge clk) begin
    shift      <= tz;
    width      <= width_next;
    field_mask <= fmask_next;
    recip      <= recip_tab[width_next];
    err        <= bad;
  end

  `ASSERT_IMPL(a_err_zero_scale, err, recip == '0 && field_mask == '0,
               "bad mask still scales a field")
  `ASSERT_IMPL(a_good_width, !err, width != '0 && int'(width) <= MaxBits,
               "good mask with illegal field width")

endmodule

### design/dbpu_chan_scale.sv
// Extracts one channel field from a pixel word and scales it to eight bits.
// Depends on dbpu_pkg; driven by the registered output of dbpu_mask_decode.
module dbpu_chan_scale #(
  parameter int MaxBits = dbpu_pkg::MAX_CHANNEL_BITS,
  parameter int KW      = $clog2(MaxBits + 1),
  parameter int MW      = MaxBits + 11
) (
  input  logic [dbpu_pkg::WORD_W-1:0]     word,
  input  logic [4:0]                      shift,
  input  logic [KW-1:0]                   width,
  input  logic [MaxBits-1:0]              field_mask,
  input  logic [MW-1:0]                   recip,
  output logic [dbpu_pkg::CHAN_W-1:0]     value
);

  localparam int NW = MaxBits + 9;
  localparam int PW = NW + MW;
  localparam int SW = $clog2(PW);
  localparam logic [NW-1:0] Scale = NW'(510);

  logic [dbpu_pkg::WORD_W-1:0] shifted;
  logic [MaxBits-1:0]          field;
  logic [NW-1:0]               numer;
  logic [PW-1:0]               prod;
  logic [SW-1:0]               post_shift;

  // value = (field*510 + top) / (2*top), with top = 2^k-1 equal to field_mask.
  always_comb begin
    shifted    = word >> shift;
    field      = shifted[MaxBits-1:0] & field_mask;
    numer      = NW'(field) * Scale + NW'(field_mask);
    prod       = PW'(numer) * PW'(recip);
    post_shift = SW'({width, 1'b0}) + SW'(10);
    value      = dbpu_pkg::CHAN_W'(prod >> post_shift);
  end

endmodule

### design/dib_bitfield_pixel_unpack_core.sv
// Turns a stream of 16, 24 or 32 bit bitmap pixel words into RGBA8888. One
// pixel request is accepted every clock cycle unless the output stalls. Each
// request is held in the input register, and its result is captured in the
// result register after mask extraction, a single multiply by a per-width
// reciprocal and a shift. The channel masks are decoded into registers after a
// configuration write, so a pixel should follow a write by at least one cycle.
// A mask that is zero, has gaps or is wider than MaxBits gives a zero channel
// and sets mask_error. Alpha is always 255.
// Depends on dbpu_pkg, dbpu_if, dbpu_mask_decode and dbpu_chan_scale.
`include "assert_macros.svh"

module dib_bitfield_pixel_unpack_core #(
  parameter int MaxBits = dbpu_pkg::MAX_CHANNEL_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [dbpu_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dbpu_pkg::CFG_DATA_W-1:0]      cfg_data,
  dbpu_pixel_in_if.sink                        pix_in,
  dbpu_pixel_out_if.source                     pix_out
);

  localparam int KW = $clog2(MaxBits + 1);
  localparam int MW = MaxBits + 11;

  // Configuration registers.
  logic                          use_bitfields;
  logic [1:0]                    depth_mode;
  logic [dbpu_pkg::WORD_W-1:0]   red_bits;
  logic [dbpu_pkg::WORD_W-1:0]   green_bits;
  logic [dbpu_pkg::WORD_W-1:0]   blue_bits;

  logic [dbpu_pkg::WORD_W-1:0]   mask_sel [3];
  logic [4:0]                    dec_shift [3];
  logic [KW-1:0]                 dec_width [3];
  logic [MaxBits-1:0]            dec_fmask [3];
  logic [MW-1:0]                 dec_recip [3];
  logic                          dec_err   [3];
  logic [dbpu_pkg::CHAN_W-1:0]   chan_val  [3];

  // Pipeline.
  logic                          in_valid_q;
  logic [dbpu_pkg::WORD_W-1:0]   word_q;
  logic                          out_valid_q;
  logic [dbpu_pkg::CHAN_W-1:0]   red_q;
  logic [dbpu_pkg::CHAN_W-1:0]   green_q;
  logic [dbpu_pkg::CHAN_W-1:0]   blue_q;
  logic                          err_q;
  logic                          out_adv;
  logic                          in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_bitfields <= 1'b0;
      depth_mode    <= dbpu_pkg::DEPTH_32;
      red_bits      <= dbpu_pkg::MASK_RED_888;
      green_bits    <= dbpu_pkg::MASK_GREEN_888;
      blue_bits     <= dbpu_pkg::MASK_BLUE_888;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dbpu_pkg::CFG_USE_BITFIELDS: use_bitfields <= cfg_data[0];
        dbpu_pkg::CFG_DEPTH_MODE:    depth_mode    <= cfg_data[1:0];
        dbpu_pkg::CFG_RED_MASK:      red_bits      <= cfg_data;
        dbpu_pkg::CFG_GREEN_MASK:    green_bits    <= cfg_data;
        dbpu_pkg::CFG_BLUE_MASK:     blue_bits     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Depth code three falls into the 8-8-8 masks like 24 and 32 bit.
  always_comb begin
    if (use_bitfields) begin
      mask_sel[0] = red_bits;
      mask_sel[1] = green_bits;
      mask_sel[2] = blue_bits;
    end else if (depth_mode == dbpu_pkg::DEPTH_16) begin
      mask_sel[0] = dbpu_pkg::MASK_RED_555;
      mask_sel[1] = dbpu_pkg::MASK_GREEN_555;
      mask_sel[2] = dbpu_pkg::MASK_BLUE_555;
    end else begin
      mask_sel[0] = dbpu_pkg::MASK_RED_888;
      mask_sel[1] = dbpu_pkg::MASK_GREEN_888;
      mask_sel[2] = dbpu_pkg::MASK_BLUE_888;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    dbpu_mask_decode #(
      .MaxBits (MaxBits),
      .KW      (KW),
      .MW      (MW)
    ) u_decode (
      .clk        (clk),
      .rst        (rst),
      .mask       (mask_sel[c]),
      .shift      (dec_shift[c]),
      .width      (dec_width[c]),
      .field_mask (dec_fmask[c]),
      .recip      (dec_recip[c]),
      .err        (dec_err[c])
    );

    dbpu_chan_scale #(
      .MaxBits (MaxBits),
      .KW      (KW),
      .MW      (MW)
    ) u_scale (
      .word       (word_q),
      .shift      (dec_shift[c]),
      .width      (dec_width[c]),
      .field_mask (dec_fmask[c]),
      .recip      (dec_recip[c]),
      .value      (chan_val[c])
    );
  end

  assign out_adv      = !out_valid_q || pix_out.ready;
  assign in_take      = !in_valid_q || out_adv;
  assign pix_in.ready = in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= pix_in.valid;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_in.valid && in_take) begin
      word_q <= pix_in.pixel_present ? pix_in.pixel_word : '0;
    end
    if (out_adv && in_valid_q) begin
      red_q   <= chan_val[0];
      green_q <= chan_val[1];
      blue_q  <= chan_val[2];
      err_q   <= dec_err[0] || dec_err[1] || dec_err[2];
    end
  end

  assign pix_out.valid      = out_valid_q;
  assign pix_out.red        = red_q;
  assign pix_out.green      = green_q;
  assign pix_out.blue       = blue_q;
  assign pix_out.alpha      = dbpu_pkg::ALPHA_OPAQUE;
  assign pix_out.mask_error = err_q;

  `ASSERT_IMPL(a_result_has_source, $rose(out_valid_q), $past(in_valid_q),
               "result appeared without a request in the input register")
  `ASSERT_NEXT(a_stalled_request_kept, in_valid_q && !out_adv, in_valid_q,
               "request in the input register dropped during a stall")

endmodule
